@@ design/sbda_pkg.sv @@
// shared types and constants for the signed binary to decimal text converter
package sbda_pkg;

    localparam int DIGIT_BITS     = 4;
    localparam int BITS_PER_STAGE = 4;

    localparam logic [6:0] ASCII_ZERO  = 7'd48;
    localparam logic [6:0] ASCII_MINUS = 7'd45;

    // control that travels with each item down the pipeline
    typedef struct packed {
        logic valid;
        logic neg;
    } t_pipe_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SIGN,
        S_SKIP,
        S_DIGIT
    } t_ser_state;

endpackage

@@ design/sbda_mag.sv @@
// entry stage: sign capture and two's complement magnitude
module sbda_mag #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [VALUE_WIDTH-1:0]   i_value,
    output sbda_pkg::t_pipe_ctl      o_ctl,
    output logic [VALUE_WIDTH-1:0]   o_mag
);
    import sbda_pkg::*;

    t_pipe_ctl              r_ctl;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic                   w_neg;

    assign w_neg = i_value[VALUE_WIDTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl.valid <= i_valid;
            r_ctl.neg   <= w_neg;
        end
    end

    // most negative value wraps to its own bit pattern, which is the right magnitude unsigned
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= w_neg ? (~i_value + VALUE_WIDTH'(1)) : i_value;
        end
    end

    assign o_ctl = r_ctl;
    assign o_mag = r_mag;

endmodule

@@ design/sbda_dabble_stage.sv @@
// one double dabble pipeline stage: BITS_PER_STAGE add-3 and shift steps
module sbda_dabble_stage #(
    parameter int NUM_DIGITS = 10,
    parameter int BIN_WIDTH  = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  sbda_pkg::t_pipe_ctl                     i_ctl,
    input  logic [NUM_DIGITS*sbda_pkg::DIGIT_BITS-1:0] i_digits,
    input  logic [BIN_WIDTH-1:0]                    i_bin,
    output sbda_pkg::t_pipe_ctl                     o_ctl,
    output logic [NUM_DIGITS*sbda_pkg::DIGIT_BITS-1:0] o_digits,
    output logic [BIN_WIDTH-1:0]                    o_bin
);
    import sbda_pkg::*;

    localparam int DW = NUM_DIGITS * DIGIT_BITS;

    t_pipe_ctl        r_ctl;
    logic [DW-1:0]    r_digits;
    logic [BIN_WIDTH-1:0] r_bin;
    logic [DW-1:0]    n_digits;
    logic [BIN_WIDTH-1:0] n_bin;

    always_comb begin
        n_digits = i_digits;
        n_bin    = i_bin;
        for (int s = 0; s < BITS_PER_STAGE; s++) begin
            for (int k = 0; k < NUM_DIGITS; k++) begin
                if (n_digits[k*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
                    n_digits[k*DIGIT_BITS +: DIGIT_BITS] =
                        n_digits[k*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
                end
            end
            {n_digits, n_bin} = {n_digits[DW-2:0], n_bin, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_digits <= n_digits;
            r_bin    <= n_bin;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_digits = r_digits;
    assign o_bin    = r_bin;

endmodule

@@ design/sbda_serial.sv @@
// character serializer: sign, leading zero skip, digits, registered output
module sbda_serial #(
    parameter int NUM_DIGITS = 10
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  sbda_pkg::t_pipe_ctl                     i_ctl,
    input  logic [NUM_DIGITS*sbda_pkg::DIGIT_BITS-1:0] i_digits,
    output logic                                    o_idle,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [6:0]                              o_char,
    output logic                                    o_last
);
    import sbda_pkg::*;

    localparam int DW = NUM_DIGITS * DIGIT_BITS;
    localparam int CW = $clog2(NUM_DIGITS + 1);

    t_ser_state      r_state;
    t_ser_state      n_state;
    logic [DW-1:0]   r_digits;
    logic [CW-1:0]   r_cnt;
    logic            r_out_valid;
    logic [6:0]      r_out_char;
    logic            r_out_last;

    logic [DIGIT_BITS-1:0] w_top;
    logic            w_slot;
    logic            w_load;
    logic            w_shift;
    logic            w_emit;
    logic [6:0]      w_char;
    logic            w_last;
    logic            w_one_left;

    assign w_top      = r_digits[DW-1 -: DIGIT_BITS];
    assign w_slot     = !r_out_valid || i_ready;
    assign w_one_left = (r_cnt == CW'(1));

    // outputs of the sequencer
    always_comb begin
        w_load  = 1'b0;
        w_shift = 1'b0;
        w_emit  = 1'b0;
        w_char  = ASCII_ZERO + {3'b000, w_top};
        w_last  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                w_load = i_ctl.valid;
            end
            S_SIGN: begin
                w_emit = w_slot;
                w_char = ASCII_MINUS;
            end
            S_SKIP: begin
                w_shift = (w_top == '0) && !w_one_left;
            end
            S_DIGIT: begin
                w_emit  = w_slot;
                w_shift = w_slot;
                w_last  = w_one_left;
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_ctl.valid) begin
                    n_state = i_ctl.neg ? S_SIGN : S_SKIP;
                end
            end
            S_SIGN: begin
                if (w_slot) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (!w_shift) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (w_slot && w_one_left) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_digits <= i_digits;
            r_cnt    <= CW'(NUM_DIGITS);
        end else if (w_shift) begin
            r_digits <= {r_digits[DW-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
            r_cnt    <= r_cnt - CW'(1);
        end
        if (w_emit) begin
            r_out_char <= w_char;
            r_out_last <= w_last;
        end
    end

    assign o_idle  = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

endmodule

@@ design/signed_binary_to_decimal_ascii.sv @@
// top level: signed binary to decimal ascii text stream
//
//  channel  dir  bus fields (lsb first)                   transfer
//  s_axis   in   tdata: value (VALUE_WIDTH, two's compl)  one number
//  m_axis   out  tdata: char_code (7), pad; tlast: last   one character
//
// a number passes a magnitude stage and ceil(VALUE_WIDTH/4) double dabble
// stages before the serializer picks it up.
// the serializer is the bottleneck: it takes no new number until it has sent
// the last one through sign, leading zero skip and digits, and an output
// stall holds it further.
// reset is synchronous, active low, and clears valid bits and the sequencer.
// a stall on the output holds the serializer; the whole pipeline holds once a
// finished number waits at its end; nothing is lost or repeated.
module signed_binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]  i_s_axis_tdata,   // value
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [7:0]                        o_m_axis_tdata,   // char_code, zero pad
    output logic                              o_m_axis_tlast    // last character of a number
);
    import sbda_pkg::*;

    // enough digits for the magnitude 2^(VALUE_WIDTH-1)
    localparam int NumDigits  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int NumStages  = (VALUE_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int BinWidth   = NumStages * BITS_PER_STAGE;
    localparam int DigitWidth = NumDigits * DIGIT_BITS;

    t_pipe_ctl              w_ctl    [0:NumStages];
    logic [DigitWidth-1:0]  w_digits [0:NumStages];
    logic [BinWidth-1:0]    w_bin    [0:NumStages];
    logic [VALUE_WIDTH-1:0] w_mag;
    logic                   w_en;
    logic                   w_ser_idle;
    logic [6:0]             w_char;

    // whole pipeline moves together; it only holds when a finished number waits
    assign w_en            = !w_ctl[NumStages].valid || w_ser_idle;
    assign o_s_axis_tready = w_en;

    sbda_mag #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_value (i_s_axis_tdata[VALUE_WIDTH-1:0]),
        .o_ctl   (w_ctl[0]),
        .o_mag   (w_mag)
    );

    // zero pad on top so the first shifts carry only zeros into the digits
    assign w_bin[0]    = BinWidth'(w_mag);
    assign w_digits[0] = '0;

    for (genvar g = 0; g < NumStages; g++) begin : g_dabble
        sbda_dabble_stage #(
            .NUM_DIGITS (NumDigits),
            .BIN_WIDTH  (BinWidth)
        ) u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_ctl    (w_ctl[g]),
            .i_digits (w_digits[g]),
            .i_bin    (w_bin[g]),
            .o_ctl    (w_ctl[g+1]),
            .o_digits (w_digits[g+1]),
            .o_bin    (w_bin[g+1])
        );
    end

    sbda_serial #(
        .NUM_DIGITS (NumDigits)
    ) u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl[NumStages]),
        .i_digits (w_digits[NumStages]),
        .o_idle   (w_ser_idle),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_char   (w_char),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, w_char};

endmodule

@@ test/testbench.sv @@
// testbench for the signed binary to decimal ascii text converter
`timescale 1ns / 1ps

// tracks the characters each accepted number must produce and checks them in order
class char_scoreboard;
    localparam int unsigned DECIMAL_RADIX = 10;
    localparam int          MAX_REPORTS   = 10;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } t_char;

    t_char pending[$];
    int    mismatches;

    function new();
        mismatches = 0;
    endfunction

    function int pending_count();
        return pending.size();
    endfunction

    // decimal text of one two's complement number, sign first, msd first
    function void note_number(input logic [31:0] value);
        bit   [31:0] mag;
        logic [6:0]  digits[$];
        bit          neg;
        neg = value[31];
        // most negative value: the 32-bit magnitude is still exact when read unsigned
        mag = neg ? (~value + 32'd1) : value;
        do begin
            digits.push_front(sbda_pkg::ASCII_ZERO + 7'(mag % DECIMAL_RADIX));
            mag = mag / DECIMAL_RADIX;
        end while (mag != 0);
        if (neg)
            pending.push_back('{code: sbda_pkg::ASCII_MINUS, last: 1'b0});
        foreach (digits[i])
            pending.push_back('{code: digits[i], last: (i == digits.size() - 1)});
    endfunction

    function void check_char(input logic [6:0] code, input logic last);
        t_char exp_char;
        if (pending.size() == 0) begin
            if (mismatches < MAX_REPORTS)
                $display("unexpected char: code %0d last %0b, nothing pending", code, last);
            mismatches++;
            return;
        end
        exp_char = pending.pop_front();
        if (code !== exp_char.code || last !== exp_char.last) begin
            if (mismatches < MAX_REPORTS)
                $display("char error: expected code %0d last %0b, got code %0d last %0b",
                         exp_char.code, exp_char.last, code, last);
            mismatches++;
        end
    endfunction
endclass

module testbench;

    localparam int VALUE_WIDTH  = 32;
    localparam int DATA_BITS    = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 212;
    localparam int CALM_ITEMS   = 40;    // final stretch runs with no idling
    localparam int PAUSE_AT     = 100;   // random item after which the sender drains
    localparam int TAIL_CYCLES  = 40;    // pipeline plus serializer latency, with margin
    localparam int STALL_LIMIT  = 2000;  // cycles without any transfer

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [DATA_BITS-1:0] i_s_axis_tdata  = '0;   // value
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [7:0]           o_m_axis_tdata;         // char_code, zero pad
    logic                 o_m_axis_tlast;         // last character of a number

    char_scoreboard sb;
    bit             calm = 1'b0;
    int             rx_hold = 0;
    int             quiet_cycles = 0;

    // extremes, digit count boundaries, both signs and alternating bit patterns
    logic [31:0] directed_values [20] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100,
        32'd999999999, 32'd1000000000, 32'd2147483647,
        -32'sd1, -32'sd9, -32'sd10, -32'sd100, -32'sd999999999, -32'sd2147483647,
        32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
        32'd1234567890, -32'sd1234567890
    };

    signed_binary_to_decimal_ascii #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // mostly a uniform digit count so short and long texts both show up often
    function automatic logic [31:0] random_number();
        longint unsigned span;
        longint unsigned mag;
        logic [31:0]     v;
        int unsigned     ndig;
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        ndig = $urandom_range(1, 10);
        span = 1;
        repeat (ndig) span = span * 10;
        mag = longint'($urandom()) % span;
        if (mag > 64'h8000_0000)
            mag = mag >> 1;
        v = 32'(mag);
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    // one transfer on the input side, with an optional idle burst ahead of it
    task automatic send_number(input logic [31:0] value);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= $urandom();
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_number(value);
    endtask

    // hold the input off until every pending character has come out
    task automatic drain_output();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_count() != 0);
    endtask

    // output side: check each transfer, stall in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_char(o_m_axis_tdata[6:0], o_m_axis_tlast);
        if (rx_hold > 0) begin
            rx_hold--;
            i_m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            rx_hold = $urandom_range(0, 4);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles where neither side moves a transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (directed_values[i])
            send_number(directed_values[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == PAUSE_AT)
                drain_output();
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            send_number(random_number());
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending_count() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ signed_binary_to_decimal_ascii.f @@
design/sbda_pkg.sv
design/sbda_mag.sv
design/sbda_dabble_stage.sv
design/sbda_serial.sv
design/signed_binary_to_decimal_ascii.sv
test/testbench.sv
